/* rtl/gfd_pkg.sv */
// Shared types, constants and helper functions for the RGB565 gray frame difference unit.
`timescale 1ns / 1ps
package gfd_pkg;

  // Configuration port widths and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_GRAY_METHOD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GATE_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PIXELS   = 2'd2;

  // Gray conversion methods; the unused code behaves as the weighted method.
  localparam logic [1:0] METHOD_WEIGHTED = 2'd0;
  localparam logic [1:0] METHOD_AVERAGE  = 2'd1;
  localparam logic [1:0] METHOD_FIXED    = 2'd2;

  // Register reset values.
  localparam logic [1:0] RESET_METHOD      = METHOD_WEIGHTED;
  localparam logic [7:0] RESET_GATE        = 8'd16;
  localparam int         RESET_FRAME_PIXELS = 76800;

  // Width of the weighted sum, large enough for the fixed-point method.
  localparam int SUM_W = 21;

  localparam logic [SUM_W-1:0] WT_R  = 21'd299;
  localparam logic [SUM_W-1:0] WT_G  = 21'd587;
  localparam logic [SUM_W-1:0] WT_B  = 21'd114;
  localparam logic [SUM_W-1:0] FX_R  = 21'd2104;
  localparam logic [SUM_W-1:0] FX_G  = 21'd4130;
  localparam logic [SUM_W-1:0] FX_B  = 21'd802;
  localparam logic [SUM_W-1:0] FX_RND = 21'd2048;
  localparam int               FX_SH = 12;

  // Reciprocals for the constant divisions by 1000 and by 3.
  localparam int               DIV1000_IN_W = 18;
  localparam int               DIV1000_K_W  = 19;
  localparam logic [DIV1000_K_W-1:0] DIV1000_K = 19'd268436;
  localparam int               DIV1000_SH   = 28;
  localparam int               DIV3_IN_W    = 10;
  localparam int               DIV3_K_W     = 11;
  localparam logic [DIV3_K_W-1:0] DIV3_K    = 11'd1366;
  localparam int               DIV3_SH      = 12;

  // Difference arithmetic constants.
  localparam logic [8:0] FULL_SCALE = 9'd255;
  localparam logic [8:0] MID_LEVEL  = 9'd128;
  localparam logic [7:0] MID_GRAY   = 8'd128;

  // Status flags that travel with each item.
  typedef struct packed {
    logic last;
    logic have_ref;
  } gfd_flags_t;

  // Scale a 5-bit channel to 0..255: c*255/31 = 8c + floor(7c/31).
  function automatic logic [7:0] scale5(input logic [4:0] c);
    logic [7:0] c7;
    logic [7:0] v;
    c7 = 8'(c) * 8'd7;
    v  = {c, 3'b000};
    for (int k = 1; k <= 7; k++) begin
      if (c7 >= 8'(31 * k)) begin
        v = v + 8'd1;
      end
    end
    return v;
  endfunction

  // Scale a 6-bit channel to 0..255: c*255/63 = 4c + floor(c/21).
  function automatic logic [7:0] scale6(input logic [5:0] c);
    logic [7:0] v;
    v = {c, 2'b00};
    for (int k = 1; k <= 3; k++) begin
      if (c >= 6'(21 * k)) begin
        v = v + 8'd1;
      end
    end
    return v;
  endfunction

endpackage

/* rtl/gfd_pixel_if.sv */
// Input channel carrying one RGB565 pixel as two bytes.
`timescale 1ns / 1ps
interface gfd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_high;
  logic [7:0] pixel_low;

  modport source (output valid, output pixel_high, output pixel_low, input ready);
  modport sink   (input valid, input pixel_high, input pixel_low, output ready);
endinterface

/* rtl/gfd_result_if.sv */
// Result channel carrying gray, repacked gray, gated difference and end of frame.
`timescale 1ns / 1ps
interface gfd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  gray_value;
  logic [15:0] gray_as_rgb565;
  logic [7:0]  gated_difference;
  logic        end_of_frame;

  modport source (output valid, output gray_value, output gray_as_rgb565,
                  output gated_difference, output end_of_frame, input ready);
  modport sink   (input valid, input gray_value, input gray_as_rgb565,
                  input gated_difference, input end_of_frame, output ready);
endinterface

/* rtl/gfd_cfg_if.sv */
// Configuration write channel carrying a register index and write data.
`timescale 1ns / 1ps
interface gfd_cfg_if;
  import gfd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* rtl/gfd_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module gfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/gfd_gray_pipe.sv */
// Four-stage gray conversion pipeline: capture, unpack and scale, weighted sum, constant division.
`timescale 1ns / 1ps
module gfd_gray_pipe #(
  parameter int POS_W = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          method,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         in_pixel,
  input  logic [POS_W-1:0]    in_pos,
  input  gfd_pkg::gfd_flags_t in_flags,
  input  logic [7:0]          prev_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_gray,
  output logic [POS_W-1:0]    out_pos,
  output gfd_pkg::gfd_flags_t out_flags,
  output logic [7:0]          out_prev
);
  import gfd_pkg::*;

  // Stage registers.
  logic             v1_r, v2_r, v3_r, v4_r;
  logic [15:0]      px1_r;
  logic [POS_W-1:0] pos1_r, pos2_r, pos3_r, pos4_r;
  gfd_flags_t       fl1_r, fl2_r, fl3_r, fl4_r;
  logic [7:0]       r2_r, g2_r, b2_r;
  logic [7:0]       prev2_r, prev3_r, prev4_r;
  logic [SUM_W-1:0] sum3_r;
  logic [7:0]       gray4_r;

  logic rdy1, rdy2, rdy3, rdy4;

  // Per-stage ready: a stage takes a new item when empty or when it moves on.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: capture the pixel and its position.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      px1_r  <= in_pixel;
      pos1_r <= in_pos;
      fl1_r  <= in_flags;
    end
  end

  // Stage 2: unpack and scale each channel; the previous-frame read lands here.
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      r2_r    <= scale5(px1_r[15:11]);
      g2_r    <= scale6(px1_r[10:5]);
      b2_r    <= scale5(px1_r[4:0]);
      prev2_r <= prev_rdata;
      pos2_r  <= pos1_r;
      fl2_r   <= fl1_r;
    end
  end

  // Stage 3: weighted sum for the selected method.
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    case (method)
      METHOD_AVERAGE: begin
        sum_nxt = SUM_W'(r2_r) + SUM_W'(g2_r) + SUM_W'(b2_r);
      end
      METHOD_FIXED: begin
        sum_nxt = SUM_W'(r2_r) * FX_R + SUM_W'(g2_r) * FX_G + SUM_W'(b2_r) * FX_B + FX_RND;
      end
      default: begin
        sum_nxt = SUM_W'(r2_r) * WT_R + SUM_W'(g2_r) * WT_G + SUM_W'(b2_r) * WT_B;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      sum3_r  <= sum_nxt;
      prev3_r <= prev2_r;
      pos3_r  <= pos2_r;
      fl3_r   <= fl2_r;
    end
  end

  // Stage 4: constant division by reciprocal multiplication, or a plain shift.
  localparam int P1000_W = DIV1000_IN_W + DIV1000_K_W;
  localparam int P3_W    = DIV3_IN_W + DIV3_K_W;

  logic [P1000_W-1:0] prod1000;
  logic [P3_W-1:0]    prod3;
  logic [7:0]         gray_nxt;

  assign prod1000 = P1000_W'(sum3_r[DIV1000_IN_W-1:0]) * P1000_W'(DIV1000_K);
  assign prod3    = P3_W'(sum3_r[DIV3_IN_W-1:0]) * P3_W'(DIV3_K);

  always_comb begin
    case (method)
      METHOD_AVERAGE: gray_nxt = prod3[DIV3_SH +: 8];
      METHOD_FIXED:   gray_nxt = sum3_r[FX_SH +: 8];
      default:        gray_nxt = prod1000[DIV1000_SH +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      gray4_r <= gray_nxt;
      prev4_r <= prev3_r;
      pos4_r  <= pos3_r;
      fl4_r   <= fl3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_gray  = gray4_r;
  assign out_pos   = pos4_r;
  assign out_flags = fl4_r;
  assign out_prev  = prev4_r;

endmodule

/* rtl/rgb565_gray_frame_diff_unit.sv */
// Top level of the RGB565 gray frame difference unit.
`timescale 1ns / 1ps
// The unit takes one RGB565 pixel per item and returns one result per item: its gray
// level, the gray repacked as RGB565, the gated difference against the same pixel of the
// previous frame, and an end-of-frame flag. It sustains one item per clock cycle while the
// result side takes its results. The edge that accepts an item captures it into the first
// of four pipeline stages (capture, scaling, weighted sum and constant division), and the
// fourth stage feeds the output register, where the difference is formed and the gray is
// written back. The previous frame lives in a RAM of MAX_FRAME_PIXELS bytes with
// one write and one registered read per cycle; it needs no clearing after reset, since
// the first frame reports a difference of 128 throughout. A short history of the last
// four written pixels forwards values that are still in flight, so very small frames
// work at full rate. Configuration is taken at any time but must only change while no
// items are in flight.
module rgb565_gray_frame_diff_unit #(
  parameter int MAX_FRAME_PIXELS = 131072
) (
  input  logic          clk,
  input  logic          rst_n,
  gfd_pixel_if.sink     in_chan,
  gfd_result_if.source  out_chan,
  gfd_cfg_if.sink       cfg_chan
);
  import gfd_pkg::*;

  localparam int AW       = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
  localparam int CW       = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
  localparam int RESET_N  = (RESET_FRAME_PIXELS > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS
                                                                     : RESET_FRAME_PIXELS;
  localparam int HIST_N   = 4;

  // Configuration registers; the frame size is held as its clamped last position.
  logic [1:0]    method_r;
  logic [7:0]    gate_r;
  logic [AW-1:0] frame_last_r;
  logic [CW-1:0] fp_ext;
  logic [AW-1:0] frame_last_nxt;
  logic          cfg_wr;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid;
  assign fp_ext         = CW'(cfg_chan.wdata);

  always_comb begin
    if (fp_ext == '0) begin
      frame_last_nxt = '0;
    end else if (fp_ext > CW'(MAX_FRAME_PIXELS)) begin
      frame_last_nxt = AW'(MAX_FRAME_PIXELS - 1);
    end else begin
      frame_last_nxt = AW'(fp_ext - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r     <= RESET_METHOD;
      gate_r       <= RESET_GATE;
      frame_last_r <= AW'(RESET_N - 1);
    end else if (cfg_wr) begin
      case (cfg_chan.reg_index)
        REG_GRAY_METHOD:    method_r     <= cfg_chan.wdata[1:0];
        REG_GATE_THRESHOLD: gate_r       <= cfg_chan.wdata[7:0];
        REG_FRAME_PIXELS:   frame_last_r <= frame_last_nxt;
        default: ;
      endcase
    end
  end

  // Position counter and reference flag, advanced as each item is accepted.
  logic [AW-1:0] pixel_position_r;
  logic          have_ref_r;
  logic [AW-1:0] pos_cur;
  logic          last_cur;
  logic          in_accept;
  logic          pipe_in_ready;
  gfd_flags_t    in_flags;

  assign in_chan.ready = pipe_in_ready;
  assign in_accept     = in_chan.valid && pipe_in_ready;
  assign pos_cur       = (pixel_position_r > frame_last_r) ? '0 : pixel_position_r;
  assign last_cur      = (pos_cur == frame_last_r);
  assign in_flags.last     = last_cur;
  assign in_flags.have_ref = have_ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_position_r <= '0;
      have_ref_r       <= 1'b0;
    end else if (in_accept) begin
      pixel_position_r <= last_cur ? '0 : pos_cur + AW'(1);
      if (last_cur) begin
        have_ref_r <= 1'b1;
      end
    end
  end

  // Previous-frame store.
  logic [7:0]    prev_rdata;
  logic          wr_en;
  logic [7:0]    p_gray;
  logic [AW-1:0] p_pos;
  gfd_flags_t    p_flags;
  logic [7:0]    p_prev;
  logic          p_valid;
  logic          p_ready;

  gfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_PIXELS),
    .AW    (AW)
  ) u_prev_frame (
    .clk   (clk),
    .we    (wr_en),
    .waddr (p_pos),
    .wdata (p_gray),
    .re    (in_accept),
    .raddr (pos_cur),
    .rdata (prev_rdata)
  );

  // Gray conversion pipeline.
  gfd_gray_pipe #(
    .POS_W (AW)
  ) u_gray_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .method     (method_r),
    .in_valid   (in_chan.valid),
    .in_ready   (pipe_in_ready),
    .in_pixel   ({in_chan.pixel_high, in_chan.pixel_low}),
    .in_pos     (pos_cur),
    .in_flags   (in_flags),
    .prev_rdata (prev_rdata),
    .out_valid  (p_valid),
    .out_ready  (p_ready),
    .out_gray   (p_gray),
    .out_pos    (p_pos),
    .out_flags  (p_flags),
    .out_prev   (p_prev)
  );

  // Output register handshake; the pipeline moves whenever it is empty or drained.
  logic out_valid_r;

  assign p_ready = !out_valid_r || out_chan.ready;
  assign wr_en   = p_valid && p_ready;

  // History of the last written pixels, newest at index 0, for items still in flight.
  logic [AW-1:0] hist_pos_r  [HIST_N];
  logic [7:0]    hist_gray_r [HIST_N];
  logic [HIST_N-1:0] hist_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (wr_en) begin
      hist_vld_r <= {hist_vld_r[HIST_N-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_pos_r[0]  <= p_pos;
      hist_gray_r[0] <= p_gray;
      for (int i = 1; i < HIST_N; i++) begin
        hist_pos_r[i]  <= hist_pos_r[i-1];
        hist_gray_r[i] <= hist_gray_r[i-1];
      end
    end
  end

  // Reference value: the newest matching history entry wins over the RAM read.
  logic [7:0] prev_eff;

  always_comb begin
    prev_eff = p_prev;
    for (int i = HIST_N - 1; i >= 0; i--) begin
      if (hist_vld_r[i] && (hist_pos_r[i] == p_pos)) begin
        prev_eff = hist_gray_r[i];
      end
    end
  end

  // Halved difference and the gate around mid level.
  logic [8:0] diff_sum;
  logic [7:0] diff_half;
  logic [8:0] gate_hi;
  logic       above_band;
  logic       below_band;
  logic [7:0] diff_nxt;

  assign diff_sum   = FULL_SCALE - 9'(prev_eff) + 9'(p_gray);
  assign diff_half  = diff_sum[8:1];
  assign gate_hi    = MID_LEVEL + 9'(gate_r);
  assign above_band = 9'(diff_half) > gate_hi;
  assign below_band = (9'(diff_half) + 9'(gate_r)) < MID_LEVEL;
  assign diff_nxt   = (p_flags.have_ref && (above_band || below_band)) ? diff_half : MID_GRAY;

  // Output register.
  logic [7:0]  gray_r;
  logic [15:0] rgb_r;
  logic [7:0]  diff_r;
  logic        eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_ready) begin
      out_valid_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gray_r <= p_gray;
      rgb_r  <= {p_gray[7:3], p_gray[7:2], p_gray[7:3]};
      diff_r <= diff_nxt;
      eof_r  <= p_flags.last;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.gray_value       = gray_r;
  assign out_chan.gray_as_rgb565   = rgb_r;
  assign out_chan.gated_difference = diff_r;
  assign out_chan.end_of_frame     = eof_r;

endmodule
